/* hw/rtl/ntcu_pkg.sv */
package ntcu_pkg;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_INT_INT = 2'd1,
        OP_INT_FLT = 2'd2,
        OP_FLT_INT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        W8  = 2'd0,
        W16 = 2'd1,
        W32 = 2'd2,
        W64 = 2'd3
    } t_width;

    typedef struct packed {
        t_op         op;
        t_width      dst;
        logic        fsrc64;
        logic [63:0] val;
    } t_cmd;

    localparam int unsigned FifoDepth = 2;

    function automatic logic [63:0] sext(input logic [63:0] v, input t_width w);
        logic [63:0] r;
        case (w)
            W8:      r = {{56{v[7]}}, v[7:0]};
            W16:     r = {{48{v[15]}}, v[15:0]};
            W32:     r = {{32{v[31]}}, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] trunc(input logic [63:0] v, input t_width w);
        logic [63:0] r;
        case (w)
            W8:      r = {56'd0, v[7:0]};
            W16:     r = {48'd0, v[15:0]};
            W32:     r = {32'd0, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/ntcu_front.sv */
module ntcu_front
    import ntcu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_kind,
    input  logic [63:0] i_src,
    output logic        o_valid,
    input  logic        i_ready,
    output t_cmd        o_cmd
);

    t_cmd r_q [FifoDepth];
    logic [$clog2(FifoDepth)-1:0] r_wp, r_rp;
    logic [$clog2(FifoDepth):0]   r_cnt;
    t_cmd   n_cmd;
    t_op    op;
    t_width sw, dw;
    logic   wr, rd;

    always_comb begin
        op = OP_NONE;
        sw = W8;
        dw = W8;
        case (i_kind)
            5'd0:  begin op = OP_INT_INT; sw = W8;  dw = W16; end
            5'd1:  begin op = OP_INT_INT; sw = W8;  dw = W32; end
            5'd2:  begin op = OP_INT_INT; sw = W8;  dw = W64; end
            5'd3:  begin op = OP_INT_FLT; sw = W8;  dw = W32; end
            5'd4:  begin op = OP_INT_FLT; sw = W8;  dw = W64; end
            5'd5:  begin op = OP_INT_INT; sw = W16; dw = W32; end
            5'd6:  begin op = OP_INT_INT; sw = W16; dw = W64; end
            5'd7:  begin op = OP_INT_FLT; sw = W16; dw = W32; end
            5'd8:  begin op = OP_INT_FLT; sw = W16; dw = W64; end
            5'd9:  begin op = OP_INT_INT; sw = W32; dw = W64; end
            5'd10: begin op = OP_INT_FLT; sw = W32; dw = W32; end
            5'd11: begin op = OP_INT_FLT; sw = W32; dw = W64; end
            5'd12: begin op = OP_INT_FLT; sw = W64; dw = W32; end
            5'd13: begin op = OP_INT_FLT; sw = W64; dw = W64; end
            5'd14: begin op = OP_FLT_INT; sw = W64; dw = W64; end
            5'd15: begin op = OP_FLT_INT; sw = W64; dw = W32; end
            5'd16: begin op = OP_FLT_INT; sw = W64; dw = W16; end
            5'd17: begin op = OP_FLT_INT; sw = W64; dw = W8;  end
            5'd18: begin op = OP_FLT_INT; sw = W32; dw = W64; end
            5'd19: begin op = OP_FLT_INT; sw = W32; dw = W32; end
            5'd20: begin op = OP_FLT_INT; sw = W32; dw = W16; end
            5'd21: begin op = OP_FLT_INT; sw = W32; dw = W8;  end
            5'd22: begin op = OP_INT_INT; sw = W64; dw = W32; end
            5'd23: begin op = OP_INT_INT; sw = W64; dw = W16; end
            5'd24: begin op = OP_INT_INT; sw = W64; dw = W8;  end
            5'd25: begin op = OP_INT_INT; sw = W32; dw = W16; end
            5'd26: begin op = OP_INT_INT; sw = W32; dw = W8;  end
            5'd27: begin op = OP_INT_INT; sw = W16; dw = W8;  end
            default: begin op = OP_NONE; end
        endcase
        n_cmd.op     = op;
        n_cmd.dst    = dw;
        n_cmd.fsrc64 = (sw == W64);
        // floats keep raw bits, integers arrive sign extended
        n_cmd.val    = (op == OP_FLT_INT) ? i_src : sext(i_src, sw);
    end

    assign o_ready = (r_cnt != FifoDepth[$clog2(FifoDepth):0]);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rp];
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{$clog2(FifoDepth){1'b0}}, wr} - {{$clog2(FifoDepth){1'b0}}, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_q[r_wp] <= n_cmd;
    end

endmodule

/* hw/rtl/ntcu_back.sv */
module ntcu_back
    import ntcu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result,
    output logic        o_invalid
);

    logic        r_valid;
    logic [63:0] r_res, n_res;
    logic        r_inv, n_inv;

    // int to float
    logic [63:0] mag;
    logic [5:0]  p;
    logic [63:0] norm;
    logic        sgn;
    logic [23:0] m32;
    logic [52:0] m64;
    logic        g, st;
    logic [24:0] r32;
    logic [53:0] r64;
    logic [7:0]  e32;
    logic [10:0] e64;

    // float to int
    logic        fs;
    logic [10:0] fe;
    logic [51:0] ff;
    logic        fnan, finf;
    logic [11:0] x;
    logic [6:0]  nm1;
    logic [63:0] sig, fmag, minv, maxv;

    always_comb begin
        sgn  = i_cmd.val[63];
        mag  = sgn ? (64'd0 - i_cmd.val) : i_cmd.val;
        p    = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (mag[i]) p = i[5:0];
        end
        norm = mag << (6'd63 - p);
        m32  = norm[63:40];
        m64  = norm[63:11];
        if (i_cmd.dst == W32) begin
            g  = norm[39];
            st = |norm[38:0];
        end else begin
            g  = norm[10];
            st = |norm[9:0];
        end
        r32 = {1'b0, m32} + {24'd0, g && (st || m32[0])};
        r64 = {1'b0, m64} + {53'd0, g && (st || m64[0])};
        e32 = 8'(p) + 8'd127 + {7'd0, r32[24]};
        e64 = 11'(p) + 11'd1023 + {10'd0, r64[53]};

        if (i_cmd.fsrc64) begin
            fs   = i_cmd.val[63];
            fe   = i_cmd.val[62:52];
            ff   = i_cmd.val[51:0];
            fnan = (fe == 11'h7ff) && (ff != 52'd0);
            finf = (fe == 11'h7ff);
            x    = {1'b0, fe} - 12'd1023;
            sig  = {11'd0, 1'b1, ff};
        end else begin
            fs   = i_cmd.val[31];
            fe   = {3'd0, i_cmd.val[30:23]};
            ff   = {i_cmd.val[22:0], 29'd0};
            fnan = (fe == 11'h0ff) && (ff != 52'd0);
            finf = (fe == 11'h0ff);
            x    = {1'b0, fe} - 12'd127;
            sig  = {11'd0, 1'b1, ff};
        end
        case (i_cmd.dst)
            W8:      nm1 = 7'd7;
            W16:     nm1 = 7'd15;
            W32:     nm1 = 7'd31;
            default: nm1 = 7'd63;
        endcase
        minv = 64'd1 << nm1;
        maxv = minv - 64'd1;
        fmag = (x[5:0] >= 6'd52) ? (sig << (x[5:0] - 6'd52)) : (sig >> (6'd52 - x[5:0]));

        n_res = 64'd0;
        n_inv = 1'b0;
        case (i_cmd.op)
            OP_INT_INT: n_res = trunc(i_cmd.val, i_cmd.dst);
            OP_INT_FLT: begin
                if (mag == 64'd0) n_res = 64'd0;
                else if (i_cmd.dst == W32)
                    n_res = {32'd0, sgn, e32, r32[24] ? r32[23:1] : r32[22:0]};
                else
                    n_res = {sgn, e64, r64[53] ? r64[52:1] : r64[51:0]};
            end
            OP_FLT_INT: begin
                if (finf) begin
                    n_inv = 1'b1;
                    n_res = fnan ? 64'd0 : trunc(fs ? minv : maxv, i_cmd.dst);
                end else if (x[11]) begin
                    n_res = 64'd0;
                end else if (x >= {5'd0, nm1}) begin
                    n_inv = !(fs && x == {5'd0, nm1} && ff == 52'd0);
                    n_res = trunc(fs ? minv : maxv, i_cmd.dst);
                end else begin
                    n_res = trunc(fs ? (64'd0 - fmag) : fmag, i_cmd.dst);
                end
            end
            default: n_res = 64'd0;
        endcase
    end

    assign o_ready   = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_result  = r_res;
    assign o_invalid = r_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= n_res;
            r_inv <= n_inv;
        end
    end

endmodule

/* hw/rtl/numeric_type_cast_unit.sv */
// channel | signals                         | contents
// in      | i_s_tvalid/o_s_tready/i_s_tdata  | kind, source_bits
// out     | o_m_tvalid/i_m_tready/o_m_tdata  | result_bits, invalid
// one request per cycle while i_m_tready is high; decode queue, then result register
// the two-entry queue lets decode and conversion stall independently
// synchronous active-low reset empties the queue and output register
module numeric_type_cast_unit
    import ntcu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,  // kind[4:0], source_bits[68:5], zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata   // result_bits[63:0], invalid[64], zero pad
);

    t_cmd        cmd;
    logic        q_valid, q_ready;
    logic [63:0] res;
    logic        inv;

    ntcu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_kind  (i_s_tdata[4:0]),
        .i_src   (i_s_tdata[68:5]),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (cmd)
    );

    ntcu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .o_ready   (q_ready),
        .i_cmd     (cmd),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_result  (res),
        .o_invalid (inv)
    );

    assign o_m_tdata = {7'd0, inv, res};

endmodule
